### rtl/core/scbm_pkg.sv
// Shared types, constants, saturating arithmetic and the microcode table of the budget meter.
package scbm_pkg;

  localparam int BUDGET_W = 64;
  localparam int COST_W   = 30;
  localparam int CNT_W    = 8;
  localparam int PROD_W   = CNT_W + COST_W;
  localparam int UPC_W    = 3;
  localparam int ADDR_W   = 5;

  typedef logic [UPC_W-1:0] upc_t;

  // Microcode addresses.
  localparam upc_t UA_IDLE    = 3'd0;
  localparam upc_t UA_BEGIN   = 3'd1;
  localparam upc_t UA_STARTUP = 3'd2;
  localparam upc_t UA_COUNT   = 3'd3;
  localparam upc_t UA_WSTART  = 3'd4;
  localparam upc_t UA_WMUL    = 3'd5;
  localparam upc_t UA_WSUB    = 3'd6;
  localparam upc_t UA_REPORT  = 3'd7;

  typedef enum logic [2:0] {
    UOP_IDLE    = 3'd0,
    UOP_BEGIN   = 3'd1,
    UOP_STARTUP = 3'd2,
    UOP_COUNT   = 3'd3,
    UOP_WSTART  = 3'd4,
    UOP_WMUL    = 3'd5,
    UOP_WSUB    = 3'd6,
    UOP_REPORT  = 3'd7
  } uop_t;

  typedef enum logic [2:0] {
    JMP_SEQ      = 3'd0,
    JMP_GOTO     = 3'd1,
    JMP_DISPATCH = 3'd2,
    JMP_SETTLE   = 3'd3,
    JMP_LOOP     = 3'd4,
    JMP_HOLD     = 3'd5
  } jmp_t;

  typedef enum logic [1:0] {
    ACT_BEGIN   = 2'd0,
    ACT_STARTUP = 2'd1,
    ACT_STEP    = 2'd2,
    ACT_FLUSH   = 2'd3
  } action_t;

  localparam logic [1:0] REG_INITIAL_CPU   = 2'd0;
  localparam logic [1:0] REG_INITIAL_MEM   = 2'd1;
  localparam logic [1:0] REG_STEP_CPU_COST = 2'd2;
  localparam logic [1:0] REG_STEP_MEM_COST = 2'd3;

  localparam logic [COST_W-1:0] RST_CPU_COST = 30'd16000;
  localparam logic [COST_W-1:0] RST_MEM_COST = 30'd100;
  localparam logic signed [BUDGET_W-1:0] STARTUP_CHARGE = 64'sd100;
  localparam logic signed [BUDGET_W-1:0] BUDGET_MAX = {1'b0, {(BUDGET_W-1){1'b1}}};
  localparam logic signed [BUDGET_W-1:0] BUDGET_MIN = {1'b1, {(BUDGET_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] step_kind;
  } in_beat_t;

  typedef struct packed {
    logic signed [BUDGET_W-1:0] cpu_left;
    logic signed [BUDGET_W-1:0] mem_left;
    logic                       within_budget;
  } out_beat_t;

  typedef struct packed {
    logic signed [BUDGET_W-1:0] init_cpu;
    logic signed [BUDGET_W-1:0] init_mem;
    logic [COST_W-1:0]          step_cpu_cost;
    logic [COST_W-1:0]          step_mem_cost;
  } cfg_t;

  typedef struct packed {
    uop_t op;
    jmp_t jmp;
    upc_t target;
  } uword_t;

  typedef struct packed {
    uop_t op;
    logic take;
  } ctrl_t;

  typedef struct packed {
    logic settle;
    logic walk_last;
    logic out_busy;
  } stat_t;

  // a - b clamped to the signed 64-bit range.
  function automatic logic signed [BUDGET_W-1:0] sat_sub(
    input logic signed [BUDGET_W-1:0] a,
    input logic signed [BUDGET_W-1:0] b
  );
    logic signed [BUDGET_W-1:0] r;
    r = a - b;
    if ((a[BUDGET_W-1] != b[BUDGET_W-1]) && (r[BUDGET_W-1] != a[BUDGET_W-1])) begin
      sat_sub = a[BUDGET_W-1] ? BUDGET_MIN : BUDGET_MAX;
    end else begin
      sat_sub = r;
    end
  endfunction

  // Control store. The settlement walk is WSTART, then WMUL and WSUB once per kind.
  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t w;
    unique case (addr)
      UA_IDLE:    w = '{op: UOP_IDLE,    jmp: JMP_DISPATCH, target: UA_IDLE};
      UA_BEGIN:   w = '{op: UOP_BEGIN,   jmp: JMP_GOTO,     target: UA_REPORT};
      UA_STARTUP: w = '{op: UOP_STARTUP, jmp: JMP_GOTO,     target: UA_REPORT};
      UA_COUNT:   w = '{op: UOP_COUNT,   jmp: JMP_SETTLE,   target: UA_REPORT};
      UA_WSTART:  w = '{op: UOP_WSTART,  jmp: JMP_SEQ,      target: UA_IDLE};
      UA_WMUL:    w = '{op: UOP_WMUL,    jmp: JMP_SEQ,      target: UA_IDLE};
      UA_WSUB:    w = '{op: UOP_WSUB,    jmp: JMP_LOOP,     target: UA_WMUL};
      UA_REPORT:  w = '{op: UOP_REPORT,  jmp: JMP_HOLD,     target: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/step_cost_budget_meter.sv
// Sequence: an accepted begin, startup or unsettled step runs its microcode word, then REPORT
// loads the result beat. A flush, and a step that reaches the slippage threshold after COUNT,
// run the settlement walk before REPORT, doing one multiply and one subtract per kind.
// Throughput: one item at a time; the next is accepted once the result sits in the output
// register (REPORT waits while the output is stalled). Reset (synchronous, rst_n low)
// clears budgets, counters and output valid and restores the default step costs.
module step_cost_budget_meter
  import scbm_pkg::*;
#(
  parameter int STEP_KINDS = 9,
  parameter int SLIPPAGE   = 200
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_beat_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_beat_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [BUDGET_W-1:0] pwdata,
  output logic [BUDGET_W-1:0] prdata,
  output logic                pready
);

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;

  scbm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scbm_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  scbm_dpath #(
    .STEP_KINDS (STEP_KINDS),
    .SLIPPAGE   (SLIPPAGE)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .cfg          (cfg),
    .in_step_kind (in_data.step_kind),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

### rtl/core/scbm_regs.sv
// Configuration register file behind the APB-style port.
module scbm_regs
  import scbm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [BUDGET_W-1:0] pwdata,
  output logic [BUDGET_W-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_INITIAL_CPU:   cfg_nxt.init_cpu      = pwdata;
        REG_INITIAL_MEM:   cfg_nxt.init_mem      = pwdata;
        REG_STEP_CPU_COST: cfg_nxt.step_cpu_cost = pwdata[COST_W-1:0];
        REG_STEP_MEM_COST: cfg_nxt.step_mem_cost = pwdata[COST_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INITIAL_CPU:   prdata = cfg_r.init_cpu;
      REG_INITIAL_MEM:   prdata = cfg_r.init_mem;
      REG_STEP_CPU_COST: prdata = BUDGET_W'(cfg_r.step_cpu_cost);
      REG_STEP_MEM_COST: prdata = BUDGET_W'(cfg_r.step_mem_cost);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_cpu      <= '0;
      cfg_r.init_mem      <= '0;
      cfg_r.step_cpu_cost <= RST_CPU_COST;
      cfg_r.step_mem_cost <= RST_MEM_COST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/scbm_useq.sv
// Microcode sequencer: microprogram counter, control store and next-address logic.
module scbm_useq
  import scbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  input  stat_t      stat,
  output ctrl_t      ctrl
);

  upc_t   upc_r, upc_nxt;
  uword_t uw;
  upc_t   upc_inc;

  assign uw        = ucode_rom(upc_r);
  assign upc_inc   = upc_r + 3'd1;
  assign in_ready  = (uw.op == UOP_IDLE);
  assign ctrl.op   = uw.op;
  assign ctrl.take = in_valid && in_ready;

  always_comb begin
    upc_nxt = upc_r;
    unique case (uw.jmp)
      JMP_SEQ:  upc_nxt = upc_inc;
      JMP_GOTO: upc_nxt = uw.target;
      JMP_DISPATCH: begin
        if (in_valid) begin
          unique case (action_t'(in_action))
            ACT_BEGIN:   upc_nxt = UA_BEGIN;
            ACT_STARTUP: upc_nxt = UA_STARTUP;
            ACT_STEP:    upc_nxt = UA_COUNT;
            ACT_FLUSH:   upc_nxt = UA_WSTART;
          endcase
        end
      end
      JMP_SETTLE: upc_nxt = stat.settle ? upc_inc : uw.target;
      JMP_LOOP:   upc_nxt = stat.walk_last ? upc_inc : uw.target;
      JMP_HOLD:   upc_nxt = stat.out_busy ? upc_r : uw.target;
      default:    upc_nxt = UA_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Only one item is in flight: the beat after an accept cannot take another.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in flight");

endmodule

### rtl/core/scbm_dpath.sv
// Datapath: budgets, per-kind counters, cost multiplier, saturating subtractor and result register.
module scbm_dpath
  import scbm_pkg::*;
#(
  parameter int STEP_KINDS = 9,
  parameter int SLIPPAGE   = 200
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_t      ctrl,
  input  cfg_t       cfg,
  input  logic [3:0] in_step_kind,
  output stat_t      stat,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data
);

  localparam int KW = (STEP_KINDS > 1) ? $clog2(STEP_KINDS) : 1;
  localparam logic [4:0]       KINDS_LIM = 5'(STEP_KINDS);
  localparam logic [CNT_W:0]   SLIP_LIM  = (CNT_W+1)'(SLIPPAGE);
  localparam logic [KW-1:0]    LAST_IDX  = KW'(STEP_KINDS - 1);

  logic [3:0]                 kind_r, kind_nxt;
  logic signed [BUDGET_W-1:0] cpu_r, cpu_nxt;
  logic signed [BUDGET_W-1:0] mem_r, mem_nxt;
  logic [CNT_W-1:0]           cnt_r [STEP_KINDS];
  logic [CNT_W-1:0]           cnt_nxt [STEP_KINDS];
  logic [CNT_W-1:0]           total_r, total_nxt;
  logic [KW-1:0]              idx_r, idx_nxt;
  logic [PROD_W-1:0]          prod_cpu_r, prod_cpu_nxt;
  logic [PROD_W-1:0]          prod_mem_r, prod_mem_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_beat_t                  out_data_r, out_data_nxt;

  logic                       kind_ok;
  logic [KW-1:0]              rd_idx;
  logic [CNT_W-1:0]           rd_cnt;
  logic                       in_budget;

  // One read port on the counters: the step kind while counting, the walk index otherwise.
  assign kind_ok = ({1'b0, kind_r} < KINDS_LIM);
  assign rd_idx  = (ctrl.op == UOP_COUNT) ? kind_r[KW-1:0] : idx_r;
  assign rd_cnt  = cnt_r[rd_idx];

  assign stat.settle    = kind_ok && (({1'b0, total_r} + 9'd1) >= SLIP_LIM);
  assign stat.walk_last = (idx_r == LAST_IDX);
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign in_budget =
    ($signed(sat_sub(cfg.init_cpu, cpu_r)) <= $signed(cfg.init_cpu)) &&
    ($signed(sat_sub(cfg.init_mem, mem_r)) <= $signed(cfg.init_mem));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    kind_nxt      = kind_r;
    cpu_nxt       = cpu_r;
    mem_nxt       = mem_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    prod_cpu_nxt  = prod_cpu_r;
    prod_mem_nxt  = prod_mem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (ctrl.op)
      UOP_IDLE: begin
        if (ctrl.take) begin
          kind_nxt = in_step_kind;
        end
      end
      UOP_BEGIN: begin
        cpu_nxt = cfg.init_cpu;
        mem_nxt = cfg.init_mem;
        for (int k = 0; k < STEP_KINDS; k++) begin
          cnt_nxt[k] = '0;
        end
        total_nxt = '0;
      end
      UOP_STARTUP: begin
        cpu_nxt = sat_sub(cpu_r, STARTUP_CHARGE);
        mem_nxt = sat_sub(mem_r, STARTUP_CHARGE);
      end
      UOP_COUNT: begin
        if (kind_ok) begin
          cnt_nxt[rd_idx] = rd_cnt + 8'd1;
          total_nxt       = total_r + 8'd1;
        end
      end
      UOP_WSTART: begin
        idx_nxt   = '0;
        total_nxt = '0;
      end
      UOP_WMUL: begin
        // A zero count gives a zero charge, so empty kinds need no skip.
        prod_cpu_nxt    = PROD_W'(rd_cnt) * PROD_W'(cfg.step_cpu_cost);
        prod_mem_nxt    = PROD_W'(rd_cnt) * PROD_W'(cfg.step_mem_cost);
        cnt_nxt[rd_idx] = '0;
      end
      UOP_WSUB: begin
        cpu_nxt = sat_sub(cpu_r, BUDGET_W'(prod_cpu_r));
        mem_nxt = sat_sub(mem_r, BUDGET_W'(prod_mem_r));
        if (!stat.walk_last) begin
          idx_nxt = idx_r + KW'(1);
        end
      end
      UOP_REPORT: begin
        if (!stat.out_busy) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.cpu_left      = cpu_r;
          out_data_nxt.mem_left      = mem_r;
          out_data_nxt.within_budget = in_budget;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_r       <= '0;
      mem_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < STEP_KINDS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      cpu_r       <= cpu_nxt;
      mem_r       <= mem_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    prod_cpu_r <= prod_cpu_nxt;
    prod_mem_r <= prod_mem_nxt;
    out_data_r <= out_data_nxt;
  end

  // Reaching the threshold always settles, so the total never passes it.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, total_r} <= SLIP_LIM))
    else $error("step total exceeded the slippage threshold");

  // A finished walk leaves the total cleared.
  a_walk_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == UOP_WSUB && stat.walk_last) |=> (total_r == '0))
    else $error("settlement walk ended with a nonzero total");

endmodule
